FILE: rtl/core/cdsr_pkg.sv
// Shared types and constants of the character display shadow refresh unit.
package cdsr_pkg;

    localparam logic [2:0] OP_PRINT   = 3'd0;
    localparam logic [2:0] OP_CLEAR   = 3'd1;
    localparam logic [2:0] OP_SET_CUR = 3'd2;
    localparam logic [2:0] OP_REF_CHG = 3'd3;
    localparam logic [2:0] OP_REF_ALL = 3'd4;

    localparam logic CMD_MOVE  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [7:0] SPACE_CHAR = 8'h20;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] char_code;
        logic [7:0] col_request;
        logic [7:0] row_request;
    } t_req;

    typedef struct packed {
        logic       command;
        logic [3:0] out_column;
        logic       out_row;
        logic [7:0] out_char;
        logic       cursor_invalid;
        logic       last;
    } t_result;

    // Write and clear controls into the grid store.
    typedef struct packed {
        logic pend_we;
        logic pend_clr;
        logic shown_we;
    } t_grid_ctl;

    // Per-cell decision of the compare unit.
    typedef struct packed {
        logic skip;
        logic need_move;
    } t_cell_dec;

endpackage

FILE: rtl/core/cdsr_grid_store.sv
// Pending and shown character grids with per-cell valid bits and registered reads.
module cdsr_grid_store
    import cdsr_pkg::*;
#(
    parameter int CELLS = 32,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_grid_ctl     i_ctl,
    input  logic [AW-1:0] i_pend_waddr,
    input  logic [7:0]    i_pend_wdata,
    input  logic [AW-1:0] i_shown_waddr,
    input  logic [7:0]    i_shown_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_pend_char,
    output logic [7:0]    o_shown_char
);

    logic [7:0]       r_pend_mem  [CELLS];
    logic [7:0]       r_shown_mem [CELLS];
    logic [CELLS-1:0] r_pend_vld;
    logic [CELLS-1:0] r_shown_vld;
    logic [7:0]       r_pend_q;
    logic [7:0]       r_shown_q;
    logic             r_pend_vq;
    logic             r_shown_vq;

    always_ff @(posedge i_clk) begin
        if (i_ctl.pend_we) begin
            r_pend_mem[i_pend_waddr] <= i_pend_wdata;
        end
        if (i_ctl.shown_we) begin
            r_shown_mem[i_shown_waddr] <= i_shown_wdata;
        end
        r_pend_q  <= r_pend_mem[i_raddr];
        r_shown_q <= r_shown_mem[i_raddr];
    end

    // A cell unwritten since reset (pending: since a clear) reads as a space.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld  <= '0;
            r_shown_vld <= '0;
            r_pend_vq   <= 1'b0;
            r_shown_vq  <= 1'b0;
        end else begin
            if (i_ctl.pend_clr) begin
                r_pend_vld <= '0;
            end else if (i_ctl.pend_we) begin
                r_pend_vld[i_pend_waddr] <= 1'b1;
            end
            if (i_ctl.shown_we) begin
                r_shown_vld[i_shown_waddr] <= 1'b1;
            end
            r_pend_vq  <= r_pend_vld[i_raddr];
            r_shown_vq <= r_shown_vld[i_raddr];
        end
    end

    assign o_pend_char  = r_pend_vq  ? r_pend_q  : SPACE_CHAR;
    assign o_shown_char = r_shown_vq ? r_shown_q : SPACE_CHAR;

endmodule

FILE: rtl/core/cdsr_cell_unit.sv
// Shared per-cell compare unit that decides skip and move for one grid cell.
module cdsr_cell_unit
    import cdsr_pkg::*;
(
    input  logic [7:0] i_pend_char,
    input  logic [7:0] i_shown_char,
    input  logic       i_all,
    input  logic       i_after_skip,
    input  logic       i_col_zero,
    output t_cell_dec  o_dec
);

    always_comb begin
        o_dec.skip      = !i_all && (i_pend_char == i_shown_char);
        o_dec.need_move = i_col_zero || (!i_all && i_after_skip);
    end

endmodule

FILE: rtl/core/char_display_shadow_refresh_unit.sv
// Top level of the character display shadow refresh unit.
// Print, clear and set-cursor requests finish in the cycle they are accepted; busy stays low.
// A refresh keeps busy high while it walks every cell, through each move and its write, and
// through the final move. Results come at most one per cycle; skips add gaps.
// Synchronous active-low reset: grids read as spaces, cursor at 0,0 and valid, block idle.
module char_display_shadow_refresh_unit
    import cdsr_pkg::*;
#(
    parameter int GRID_COLS = 16,
    parameter int GRID_ROWS = 2
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_req    i_req,
    output logic    busy,
    output logic    o_strobe,
    output t_result o_result
);

    localparam int CELLS = GRID_COLS * GRID_ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int COL_W = $clog2(GRID_COLS);
    localparam int ROW_W = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_WRITE,
        S_FINAL
    } t_state;

    t_state r_state, n_state;

    // Text cursor: flat cell index plus column and row, kept in step to avoid a divide.
    logic [AW-1:0]    r_cur_idx, n_cur_idx;
    logic [COL_W-1:0] r_cur_col, n_cur_col;
    logic [ROW_W-1:0] r_cur_row, n_cur_row;
    logic             r_bad, n_bad;

    // Refresh walk position.
    logic [AW-1:0]    r_cell, n_cell;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic             r_all, n_all;
    logic             r_after_skip, n_after_skip;

    logic             r_strobe, n_strobe;
    t_result          r_result, n_result;

    t_grid_ctl        grid_ctl;
    logic [7:0]       pend_char;
    logic [7:0]       shown_char;
    t_cell_dec        dec;
    logic             accept;
    logic             last_cell;
    logic [COL_W-1:0] req_col;
    logic [ROW_W-1:0] req_row;
    logic [7:0]       walk_col8;
    logic [7:0]       walk_row8;
    logic [7:0]       cur_col8;
    logic [7:0]       cur_row8;

    // The read address follows the next walk position, so the registered read data
    // always belongs to the cell held in r_cell.
    cdsr_grid_store #(
        .CELLS(CELLS),
        .AW   (AW)
    ) u_grid (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (grid_ctl),
        .i_pend_waddr (r_cur_idx),
        .i_pend_wdata (i_req.char_code),
        .i_shown_waddr(r_cell),
        .i_shown_wdata(pend_char),
        .i_raddr      (n_cell),
        .o_pend_char  (pend_char),
        .o_shown_char (shown_char)
    );

    cdsr_cell_unit u_cell (
        .i_pend_char (pend_char),
        .i_shown_char(shown_char),
        .i_all       (r_all),
        .i_after_skip(r_after_skip),
        .i_col_zero  (r_col == '0),
        .o_dec       (dec)
    );

    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign last_cell = (r_cell == AW'(CELLS - 1));
    assign req_col   = i_req.col_request[COL_W-1:0];
    assign req_row   = ROW_W'(i_req.row_request);
    assign walk_col8 = 8'(r_col);
    assign walk_row8 = 8'(r_row);
    assign cur_col8  = 8'(r_cur_col);
    assign cur_row8  = 8'(r_cur_row);

    always_comb begin
        n_state      = r_state;
        n_cur_idx    = r_cur_idx;
        n_cur_col    = r_cur_col;
        n_cur_row    = r_cur_row;
        n_bad        = r_bad;
        n_cell       = r_cell;
        n_col        = r_col;
        n_row        = r_row;
        n_all        = r_all;
        n_after_skip = r_after_skip;
        n_strobe     = 1'b0;
        n_result     = '0;
        grid_ctl     = '0;

        case (r_state)
            S_IDLE: begin
                n_cell = '0;
                n_col  = '0;
                n_row  = '0;
                if (accept) begin
                    case (i_req.operation)
                        OP_PRINT: begin
                            // An invalid cursor swallows the print; the last column
                            // invalidates the cursor instead of wrapping.
                            if (!r_bad) begin
                                grid_ctl.pend_we = 1'b1;
                                if (r_cur_col == COL_W'(GRID_COLS - 1)) begin
                                    n_cur_idx = '0;
                                    n_cur_col = '0;
                                    n_cur_row = '0;
                                    n_bad     = 1'b1;
                                end else begin
                                    n_cur_idx = r_cur_idx + AW'(1);
                                    n_cur_col = r_cur_col + COL_W'(1);
                                end
                            end
                        end
                        OP_CLEAR: begin
                            grid_ctl.pend_clr = 1'b1;
                            n_cur_idx = '0;
                            n_cur_col = '0;
                            n_cur_row = '0;
                            n_bad     = 1'b0;
                        end
                        OP_SET_CUR: begin
                            if ((32'(i_req.col_request) >= GRID_COLS) ||
                                (32'(i_req.row_request) >= GRID_ROWS)) begin
                                n_cur_idx = '0;
                                n_cur_col = '0;
                                n_cur_row = '0;
                                n_bad     = 1'b1;
                            end else begin
                                n_cur_idx = AW'(32'(req_row) * GRID_COLS + 32'(req_col));
                                n_cur_col = req_col;
                                n_cur_row = req_row;
                                n_bad     = 1'b0;
                            end
                        end
                        OP_REF_CHG, OP_REF_ALL: begin
                            n_all        = (i_req.operation == OP_REF_ALL);
                            n_after_skip = 1'b1;
                            n_state      = S_EVAL;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_EVAL, S_WRITE: begin
                if (r_state == S_EVAL && dec.skip) begin
                    n_after_skip = 1'b1;
                end else if (r_state == S_EVAL && dec.need_move) begin
                    // Move to this cell first; the write follows next cycle.
                    n_strobe            = 1'b1;
                    n_result.command    = CMD_MOVE;
                    n_result.out_column = walk_col8[3:0];
                    n_result.out_row    = walk_row8[0];
                    n_state             = S_WRITE;
                end else begin
                    n_strobe          = 1'b1;
                    n_result.command  = CMD_WRITE;
                    n_result.out_char = pend_char;
                    grid_ctl.shown_we = 1'b1;
                    n_after_skip      = 1'b0;
                    n_state           = S_EVAL;
                end

                // Step to the next cell unless a move is waiting for its write.
                if (n_state == S_EVAL) begin
                    if (last_cell) begin
                        n_cell  = '0;
                        n_col   = '0;
                        n_row   = '0;
                        n_state = S_FINAL;
                    end else begin
                        n_cell = r_cell + AW'(1);
                        if (r_col == COL_W'(GRID_COLS - 1)) begin
                            n_col = '0;
                            n_row = r_row + ROW_W'(1);
                        end else begin
                            n_col = r_col + COL_W'(1);
                        end
                    end
                end
            end

            S_FINAL: begin
                // Park the display cursor on the text cursor; an invalid cursor is flagged.
                n_strobe                = 1'b1;
                n_result.command        = CMD_MOVE;
                n_result.last           = 1'b1;
                n_result.cursor_invalid = r_bad;
                if (!r_bad) begin
                    n_result.out_column = cur_col8[3:0];
                    n_result.out_row    = cur_row8[0];
                end
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cur_idx    <= '0;
            r_cur_col    <= '0;
            r_cur_row    <= '0;
            r_bad        <= 1'b0;
            r_cell       <= '0;
            r_col        <= '0;
            r_row        <= '0;
            r_all        <= 1'b0;
            r_after_skip <= 1'b1;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cur_idx    <= n_cur_idx;
            r_cur_col    <= n_cur_col;
            r_cur_row    <= n_cur_row;
            r_bad        <= n_bad;
            r_cell       <= n_cell;
            r_col        <= n_col;
            r_row        <= n_row;
            r_all        <= n_all;
            r_after_skip <= n_after_skip;
            r_strobe     <= n_strobe;
        end
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // Every refresh ends in exactly one final move marked last.
    a_final_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINAL) |=> (o_strobe && o_result.last))
        else $error("final state did not deliver a last command");

    // Only the final move may carry the invalid cursor flag.
    a_inval_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.cursor_invalid) |-> (o_result.last &&
        o_result.command == CMD_MOVE))
        else $error("invalid cursor flag outside the final move");

    // An invalid cursor always sits at cell zero.
    a_bad_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bad |-> (r_cur_idx == '0 && r_cur_col == '0 && r_cur_row == '0))
        else $error("invalid cursor not parked at zero");

    // A move to a cell is always followed by the write of that cell.
    a_move_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |=> (o_strobe && o_result.command == CMD_WRITE))
        else $error("move command not followed by a write");

    // An accepted refresh request makes the block busy.
    a_ref_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_req.operation == OP_REF_CHG || i_req.operation == OP_REF_ALL))
        |=> busy)
        else $error("refresh request did not start a walk");

endmodule

FILE: bench/char_display_shadow_refresh_unit_tb.sv
// Self-checking testbench for the character display shadow refresh unit.
module char_display_shadow_refresh_unit_tb;
    import cdsr_pkg::*;

    localparam int COLS  = 16;
    localparam int ROWS  = 2;
    localparam int CELLS = COLS * ROWS;

    // Operation codes above refresh-all are decoded as no-ops by the block.
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    // Refresh-all: every cell, one move per row and the closing move.
    localparam int REFRESH_CYCLES = CELLS + ROWS + 1;
    localparam int RANDOM_ITEMS   = 310;
    // The last stretch of requests goes back to back with no idle gaps.
    localparam int CALM_TAIL      = 60;

    // The shadow grids, the cursor and the queue of display commands that
    // the block still owes. A request is noted when it is accepted, and each
    // strobed command is checked against the oldest one in the queue.
    class refresh_scoreboard;
        logic [7:0]  pend_cells [CELLS];
        logic [7:0]  shown_cells[CELLS];
        int unsigned cur_idx;
        bit          cur_bad;
        t_result     cmd_expected[$];
        int unsigned n_req;
        int unsigned n_refresh;
        int unsigned n_checked;
        int unsigned n_invalid_end;
        int unsigned n_bad;

        function new();
            foreach (pend_cells[p]) begin
                pend_cells[p]  = SPACE_CHAR;
                shown_cells[p] = SPACE_CHAR;
            end
            cur_idx       = 0;
            cur_bad       = 1'b0;
            n_req         = 0;
            n_refresh     = 0;
            n_checked     = 0;
            n_invalid_end = 0;
            n_bad         = 0;
        endfunction

        function void push_cmd(logic cmd, int col, int row, logic [7:0] ch, logic inval,
                               logic fin);
            t_result r;
            r.command        = cmd;
            r.out_column     = 4'(col);
            r.out_row        = 1'(row);
            r.out_char       = ch;
            r.cursor_invalid = inval;
            r.last           = fin;
            cmd_expected.push_back(r);
        endfunction

        function void note_request(t_req r);
            bit after_skip;
            bit send_all;
            int col;
            int row;
            n_req++;
            case (r.operation)
                OP_PRINT: begin
                    // A print at an invalid cursor is dropped. Printing into the last
                    // column leaves the cursor invalid rather than wrapping it.
                    if (!cur_bad) begin
                        pend_cells[cur_idx] = r.char_code;
                        if ((cur_idx % COLS) < COLS - 1) begin
                            cur_idx++;
                        end else begin
                            cur_idx = 0;
                            cur_bad = 1'b1;
                        end
                    end
                end
                OP_CLEAR: begin
                    foreach (pend_cells[p]) pend_cells[p] = SPACE_CHAR;
                    cur_idx = 0;
                    cur_bad = 1'b0;
                end
                OP_SET_CUR: begin
                    if (r.col_request >= COLS || r.row_request >= ROWS) begin
                        cur_idx = 0;
                        cur_bad = 1'b1;
                    end else begin
                        cur_idx = r.row_request * COLS + r.col_request;
                        cur_bad = 1'b0;
                    end
                end
                OP_REF_CHG, OP_REF_ALL: begin
                    send_all   = (r.operation == OP_REF_ALL);
                    after_skip = 1'b1;
                    n_refresh++;
                    for (int p = 0; p < CELLS; p++) begin
                        col = p % COLS;
                        row = p / COLS;
                        if (!send_all && pend_cells[p] == shown_cells[p]) begin
                            after_skip = 1'b1;
                        end else begin
                            // A move opens every row and every run that follows a skip.
                            if (col == 0 || (!send_all && after_skip))
                                push_cmd(CMD_MOVE, col, row, 8'h00, 1'b0, 1'b0);
                            push_cmd(CMD_WRITE, 0, 0, pend_cells[p], 1'b0, 1'b0);
                            shown_cells[p] = pend_cells[p];
                            after_skip     = 1'b0;
                        end
                    end
                    // The closing move parks the display cursor on the text cursor.
                    if (cur_bad) begin
                        push_cmd(CMD_MOVE, 0, 0, 8'h00, 1'b1, 1'b1);
                        n_invalid_end++;
                    end else begin
                        push_cmd(CMD_MOVE, cur_idx % COLS, cur_idx / COLS, 8'h00, 1'b0, 1'b1);
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function void flag(string what, t_result e, t_result g);
            n_bad++;
            if (n_bad <= 10)
                $display("MISMATCH (%s) at %0t: expected cmd=%0d col=%0d row=%0d char=%02h inv=%0d last=%0d, got cmd=%0d col=%0d row=%0d char=%02h inv=%0d last=%0d",
                         what, $realtime, e.command, e.out_column, e.out_row, e.out_char,
                         e.cursor_invalid, e.last, g.command, g.out_column, g.out_row,
                         g.out_char, g.cursor_invalid, g.last);
        endfunction

        function void check_command(t_result got);
            t_result e;
            string   bad_fields;
            if (cmd_expected.size() == 0) begin
                flag("no command expected", '0, got);
                return;
            end
            e          = cmd_expected.pop_front();
            bad_fields = "";
            n_checked++;
            if (got.command !== e.command)               bad_fields = {bad_fields, " command"};
            if (got.out_column !== e.out_column)         bad_fields = {bad_fields, " column"};
            if (got.out_row !== e.out_row)               bad_fields = {bad_fields, " row"};
            if (got.out_char !== e.out_char)             bad_fields = {bad_fields, " char"};
            if (got.cursor_invalid !== e.cursor_invalid) bad_fields = {bad_fields, " invalid"};
            if (got.last !== e.last)                     bad_fields = {bad_fields, " last"};
            if (bad_fields != "")
                flag({"field", bad_fields}, e, got);
        endfunction
    endclass

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    t_req    req_bus;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    refresh_scoreboard sb;

    char_display_shadow_refresh_unit #(
        .GRID_COLS(COLS),
        .GRID_ROWS(ROWS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (req_bus),
        .busy    (busy),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    // Free-running clock with a period of 10 time units.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Everything is sampled at the rising edge, where the block sees it too.
    // A request counts as accepted when start is high and busy is low. Strobed
    // commands cannot be held off, so each one is checked in the cycle it shows.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe === 1'b1)
                sb.check_command(o_result);
            if (start && busy === 1'b0)
                sb.note_request(req_bus);
        end
    end

    // Present one request at the falling edge and hold it until the block takes it.
    // Start stays high when the next request follows directly, so it is assigned
    // only once per falling edge.
    task automatic send_op(logic [2:0] op, logic [7:0] ch, logic [7:0] col, logic [7:0] row);
        t_req r;
        r.operation   = op;
        r.char_code   = ch;
        r.col_request = col;
        r.row_request = row;
        @(negedge i_clk);
        start   <= 1'b1;
        req_bus <= r;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
    endtask

    // Drop start for a number of cycles while the request bus carries noise.
    task automatic idle_gap(int unsigned cycles);
        @(negedge i_clk);
        start   <= 1'b0;
        req_bus <= t_req'($urandom);
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Hold back until the block has delivered every command it owes.
    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.cmd_expected.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Pick a character: often a space or a fixed letter, so that refresh-changed
    // finds cells equal to what the display shows and has runs to skip.
    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 3))
            0:       return SPACE_CHAR;
            1:       return 8'h41;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Safety net: a hung handshake or a missing command ends the run here.
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int unsigned pick;
        logic [7:0]  col;
        logic [7:0]  row;

        sb      = new();
        i_rst_n = 1'b0;
        start   = 1'b0;
        req_bus = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Straight out of reset every cell is sent: the longest burst.
        send_op(OP_REF_ALL, 8'h00, 8'h00, 8'h00);
        // Nothing differs now, so only the closing move comes back.
        send_op(OP_REF_CHG, 8'h00, 8'h00, 8'h00);
        // Extreme characters in the first two cells.
        send_op(OP_PRINT, 8'h00, 8'h00, 8'h00);
        send_op(OP_PRINT, 8'hFF, 8'hFF, 8'hFF);
        send_op(OP_REF_CHG, 8'h00, 8'h00, 8'h00);
        // Print into the very last cell: the cursor goes invalid and the next print
        // is dropped, so the refresh ends on an invalid-cursor move.
        send_op(OP_SET_CUR, 8'h00, 8'(COLS - 1), 8'(ROWS - 1));
        send_op(OP_PRINT, 8'h41, 8'h00, 8'h00);
        send_op(OP_PRINT, 8'h42, 8'h00, 8'h00);
        send_op(OP_REF_CHG, 8'h00, 8'h00, 8'h00);
        // A space over a space is skipped, the character after it needs a new move.
        send_op(OP_SET_CUR, 8'h00, 8'd5, 8'd0);
        send_op(OP_PRINT, SPACE_CHAR, 8'h00, 8'h00);
        send_op(OP_PRINT, 8'h7E, 8'h00, 8'h00);
        send_op(OP_REF_CHG, 8'h00, 8'h00, 8'h00);
        // Out-of-range cursor requests, with refreshes to expose the flag.
        send_op(OP_SET_CUR, 8'h00, 8'(COLS), 8'd0);
        send_op(OP_REF_CHG, 8'h00, 8'h00, 8'h00);
        send_op(OP_SET_CUR, 8'h00, 8'd0, 8'(ROWS));
        send_op(OP_SET_CUR, 8'h00, 8'hFF, 8'hFF);
        send_op(OP_REF_ALL, 8'h00, 8'h00, 8'h00);
        // Unused operation codes must leave everything alone.
        for (int op = OP_UNUSED_LO; op <= OP_UNUSED_HI; op++)
            send_op(3'(op), 8'hFF, 8'hFF, 8'hFF);
        // Clear brings the cursor back and blanks the pending grid.
        send_op(OP_CLEAR, 8'h00, 8'h00, 8'h00);
        send_op(OP_REF_CHG, 8'h00, 8'h00, 8'h00);

        // Random part. Mostly cursor placement and runs of prints with refreshes in
        // between, plus clears and unused codes as noise.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2)
                wait_drained();
            if (n < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0)
                idle_gap($urandom_range(1, 9));
            pick = $urandom_range(0, 99);
            col  = 8'($urandom_range(0, 255));
            row  = 8'($urandom_range(0, 255));
            if (pick < 45) begin
                send_op(OP_PRINT, pick_char(), col, row);
            end else if (pick < 62) begin
                // Most cursor requests land inside the grid; the rest use the full range.
                if ($urandom_range(0, 4) != 0) begin
                    col = 8'($urandom_range(0, COLS - 1));
                    row = 8'($urandom_range(0, ROWS - 1));
                end
                send_op(OP_SET_CUR, 8'($urandom_range(0, 255)), col, row);
            end else if (pick < 66) begin
                send_op(OP_CLEAR, 8'($urandom_range(0, 255)), col, row);
            end else if (pick < 82) begin
                send_op(OP_REF_CHG, 8'($urandom_range(0, 255)), col, row);
            end else if (pick < 92) begin
                send_op(OP_REF_ALL, 8'($urandom_range(0, 255)), col, row);
            end else begin
                send_op(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)),
                        8'($urandom_range(0, 255)), col, row);
            end
        end
        send_op(OP_REF_CHG, 8'h00, 8'h00, 8'h00);

        // Let the last refresh finish, then watch a while longer for stray strobes.
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.cmd_expected.size() != 0) @(posedge i_clk);
        repeat (2 * (REFRESH_CYCLES + 2)) @(posedge i_clk);

        $display("Run covered %0d requests with %0d refreshes; %0d display commands checked.",
                 sb.n_req, sb.n_refresh, sb.n_checked);
        $display("%0d refreshes ended on an invalid cursor, %0d mismatches, %0d commands missing.",
                 sb.n_invalid_end, sb.n_bad, sb.cmd_expected.size());
        if (sb.n_bad == 0 && sb.cmd_expected.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
